// ===== src/lsh_pkg.sv =====
// Shared types and constants for the 5-point Laplacian sharpening block.
// No dependencies; every other file of the block imports this package.
package lsh_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = ADDR_W + 1;
   localparam int HEIGHT_W  = 16;
   localparam int PIX_W     = 8;
   localparam int SUM_W     = PIX_W + 4;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = HEIGHT_W'(480);

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    value;
      logic [HEIGHT_W-1:0] out_row;
      logic [ADDR_W-1:0]   out_col;
      logic                frame_last;
   } rsp_type;

   typedef struct packed {
      logic                emit;
      logic                kind;
      logic                border;
      logic                last;
      logic [PIX_W-1:0]    pixel;
      logic [HEIGHT_W-1:0] orow;
      logic [ADDR_W-1:0]   ocol;
      logic [ADDR_W-1:0]   col;
   } tag_type;

endpackage

// ===== src/lsh_ctrl.sv =====
// Position counters, flush countdown and first pipeline register.
// Depends on lsh_pkg.
module lsh_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lsh_pkg::WIDTH_W-1:0]   frame_width,
   input  logic [lsh_pkg::HEIGHT_W-1:0]  frame_height,
   input  logic                          accept,
   input  lsh_pkg::req_type              req,
   input  logic                          adv,
   output logic [lsh_pkg::ADDR_W-1:0]    rd_addr,
   output logic                          tag_valid,
   output lsh_pkg::tag_type              tag
);
   import lsh_pkg::*;

   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [WIDTH_W-1:0]  pend_ff, pend_in;
   logic                valid_ff, valid_in;
   tag_type             tag_ff, tag_in;

   logic [WIDTH_W-1:0]  w_eff, w_m1, w_p1, c_nx;
   logic [HEIGHT_W-1:0] h_eff, h_m1, h_m2, r1, r0;
   logic [ADDR_W-1:0]   c0;
   logic                wrap0;

   always_comb begin
      if (frame_width < WIDTH_W'(3)) begin
         w_eff = WIDTH_W'(3);
      end else if (frame_width > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width;
      end
      h_eff = (frame_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : frame_height;
      w_m1  = w_eff - WIDTH_W'(1);
      w_p1  = w_eff + WIDTH_W'(1);
      h_m1  = h_eff - HEIGHT_W'(1);
      h_m2  = h_eff - HEIGHT_W'(2);

      wrap0 = {1'b0, col_ff} >= w_eff;
      c0    = wrap0 ? '0 : col_ff;
      r1    = wrap0 ? row_ff + HEIGHT_W'(1) : row_ff;
      r0    = (r1 >= h_eff) ? '0 : r1;
      c_nx  = {1'b0, c0} + WIDTH_W'(1);
   end

   assign rd_addr = c0;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      pend_in = pend_ff;
      tag_in = '0;
      tag_in.kind = req.kind;
      tag_in.pixel = req.pixel;
      tag_in.col = c0;
      tag_in.border = 1'b1;
      if (req.kind == KIND_FLUSH) begin
         if (pend_ff != '0) begin
            tag_in.emit = 1'b1;
            pend_in = pend_ff - WIDTH_W'(1);
            tag_in.last = (pend_in == '0);
            if (pend_ff >= w_p1) begin
               tag_in.orow = h_m2;
               tag_in.ocol = w_m1[ADDR_W-1:0];
            end else begin
               tag_in.orow = h_m1;
               tag_in.ocol = ADDR_W'(w_eff - pend_ff);
            end
         end
      end else begin
         pend_in = '0;
         tag_in.emit = (r0 >= HEIGHT_W'(2)) || (r0 == HEIGHT_W'(1) && c0 != '0);
         if (c0 == '0) begin
            tag_in.orow = r0 - HEIGHT_W'(2);
            tag_in.ocol = w_m1[ADDR_W-1:0];
         end else begin
            tag_in.orow = r0 - HEIGHT_W'(1);
            tag_in.ocol = c0 - ADDR_W'(1);
         end
         tag_in.border = !(tag_in.orow != '0 && tag_in.orow < h_m1 &&
                           tag_in.ocol != '0 && {1'b0, tag_in.ocol} < w_m1);
         if (c_nx >= w_eff) begin
            col_in = '0;
            if (r0 + HEIGHT_W'(1) >= h_eff) begin
               row_in = '0;
               pend_in = w_p1;
            end else begin
               row_in = r0 + HEIGHT_W'(1);
            end
         end else begin
            col_in = c_nx[ADDR_W-1:0];
            row_in = r0;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (adv) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         pend_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= tag_in;
      end
   end

   assign tag_valid = valid_ff;
   assign tag = tag_ff;

endmodule

// ===== src/lsh_window.sv =====
// Line memories, 3x3 window registers and the sharpening arithmetic.
// Depends on lsh_pkg.
module lsh_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [lsh_pkg::ADDR_W-1:0]  rd_addr,
   input  logic                        adv,
   input  lsh_pkg::tag_type            tag,
   output logic                        push,
   output lsh_pkg::rsp_type            push_data
);
   import lsh_pkg::*;

   logic [PIX_W-1:0] above_mem [MAX_WIDTH];
   logic [PIX_W-1:0] two_mem   [MAX_WIDTH];
   logic [PIX_W-1:0] above_rd_ff, two_rd_ff;

   logic [PIX_W-1:0] up_ff, left_ff, ctr_ff, prev_ff;
   logic [PIX_W-1:0] up_in, left_in, ctr_in, prev_in;

   logic             wr_en;
   logic [SUM_W-1:0] pos, neg;
   logic signed [SUM_W-1:0] s;
   logic [PIX_W-1:0] sat;

   assign wr_en = adv && tag.kind == KIND_PIXEL;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         above_rd_ff <= above_mem[rd_addr];
      end
      if (wr_en) begin
         above_mem[tag.col] <= tag.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         two_rd_ff <= two_mem[rd_addr];
      end
      if (wr_en) begin
         two_mem[tag.col] <= above_rd_ff;
      end
   end

   // up = row above, left/ctr = middle row, right neighbor is the fresh line read
   always_comb begin
      up_in = up_ff;
      left_in = left_ff;
      ctr_in = ctr_ff;
      prev_in = prev_ff;
      if (wr_en) begin
         up_in = two_rd_ff;
         left_in = ctr_ff;
         ctr_in = above_rd_ff;
         prev_in = tag.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= '0;
         left_ff <= '0;
         ctr_ff <= '0;
         prev_ff <= '0;
      end else begin
         up_ff <= up_in;
         left_ff <= left_in;
         ctr_ff <= ctr_in;
         prev_ff <= prev_in;
      end
   end

   always_comb begin
      pos = {2'b00, ctr_ff, 2'b00} + {4'b0000, ctr_ff};
      neg = {4'b0000, up_ff} + {4'b0000, left_ff} + {4'b0000, above_rd_ff}
          + {4'b0000, prev_ff};
      s = $signed(pos) - $signed(neg);
      if (s < 0) begin
         sat = '0;
      end else if (s > SUM_W'(255)) begin
         sat = '1;
      end else begin
         sat = s[PIX_W-1:0];
      end
   end

   assign push = adv && tag.emit;
   assign push_data.value = tag.border ? '0 : sat;
   assign push_data.out_row = tag.orow;
   assign push_data.out_col = tag.ocol;
   assign push_data.frame_last = tag.last;

endmodule

// ===== src/lsh_out_fifo.sv =====
// Two-entry result queue between the pipeline and the result channel.
// Depends on lsh_pkg.
module lsh_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lsh_pkg::rsp_type push_data,
   output logic             space,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsh_pkg::rsp_type rsp_payload
);
   import lsh_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop = rsp_valid && rsp_ready;
   assign space = cnt_ff != 2'd2;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_payload = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/laplacian_sharpen_3x3.sv =====
// 5-point Laplacian sharpening of an 8-bit grayscale raster stream, with a
// small register port for frame size. One beat is taken every clock cycle
// unless the pipeline register is full and the result queue is too; two
// line memories with a registered read hold the rows above, so a beat reads
// its column at acceptance and writes it back one stage later. Results trail
// the input stream by one line plus one pixel. No clearing pass after reset.
// Depends on lsh_pkg, lsh_ctrl, lsh_window and lsh_out_fifo.
module laplacian_sharpen_3x3 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lsh_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsh_pkg::rsp_type rsp_payload,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lsh_pkg::*;

   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic                csr_wr;

   logic               accept, adv, space, tag_valid, push;
   logic [ADDR_W-1:0]  rd_addr;
   tag_type            tag;
   rsp_type            push_data;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_FRAME_WIDTH:  frame_width_ff <= csr_pwdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         CSR_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign adv = tag_valid && space;
   assign req_ready = !tag_valid || space;
   assign accept = req_valid && req_ready;

   lsh_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .accept       (accept),
      .req          (req_payload),
      .adv          (adv),
      .rd_addr      (rd_addr),
      .tag_valid    (tag_valid),
      .tag          (tag)
   );

   lsh_window u_window (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (rd_addr),
      .adv       (adv),
      .tag       (tag),
      .push      (push),
      .push_data (push_data)
   );

   lsh_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/lsh_checker.sv =====
// Port-level checks for laplacian_sharpen_3x3, attached by bind.
// Depends on lsh_pkg and the top level.
module lsh_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lsh_pkg::rsp_type rsp_payload
);
   import lsh_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out_row == '0 || rsp_payload.out_col == '0)
      |-> rsp_payload.value == '0)
      else $error("border pixel not zero");

   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_last |-> rsp_payload.value == '0)
      else $error("last beat of frame not a border zero");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== dv/laplacian_sharpen_3x3_test.sv =====
// Self-checking testbench for laplacian_sharpen_3x3: drives pixel and flush beats,
// predicts every output pixel and compares each field at the result port.
// Depends on lsh_pkg and the laplacian_sharpen_3x3 RTL.
module laplacian_sharpen_3x3_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lsh_pkg::*;

   localparam int IDLE_CYCLES  = 10;
   localparam int RANDOM_ITEMS = 900;
   localparam int TIMEOUT_NS   = 5_000_000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   laplacian_sharpen_3x3 DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RESET;
   logic [HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RESET;
   bit [PIX_W-1:0]      line_above_px [MAX_WIDTH];
   bit [PIX_W-1:0]      line_two_px [MAX_WIDTH];
   int                  window_px [6];
   int                  in_row = 0;
   int                  in_col = 0;
   int                  pending_border = 0;

   rsp_type expected_pixels [$];
   rsp_type front_pixel;

   int mismatches      = 0;
   int results_checked = 0;
   int beats_sent      = 0;
   int counted_items   = 0;
   int frames_done     = 0;
   int burst_left      = 0;
   int hold_request    = 0;
   int hold_left       = 0;
   int ready_mode      = 0;
   int mode_left       = 0;

   task automatic sharpen_predict(input req_type item, output bit emitted);
      int      w, h, r, c, t, m, s, orow, ocol;
      rsp_type exp_px;
      w = int'(width_reg);
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(height_reg);
      if (h < 3) h = 3;
      emitted = 1'b0;
      if (item.kind == KIND_FLUSH) begin
         if (pending_border == 0) return;
         if (pending_border >= w + 1) begin
            orow = h - 2;
            ocol = w - 1;
         end else begin
            orow = h - 1;
            ocol = w - pending_border;
         end
         pending_border--;
         exp_px.value      = '0;
         exp_px.out_row    = orow[HEIGHT_W-1:0];
         exp_px.out_col    = ocol[ADDR_W-1:0];
         exp_px.frame_last = (pending_border == 0);
         expected_pixels.push_back(exp_px);
         emitted = 1'b1;
         return;
      end
      pending_border = 0;
      r = in_row;
      c = in_col;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) r = 0;
      t = int'(line_two_px[c]);
      m = int'(line_above_px[c]);
      line_two_px[c]   = m[PIX_W-1:0];
      line_above_px[c] = item.pixel;
      window_px[0] = window_px[1];
      window_px[1] = t;
      window_px[2] = window_px[3];
      window_px[3] = window_px[4];
      window_px[4] = m;
      if (r >= 2 || (r == 1 && c >= 1)) begin
         if (c == 0) begin
            orow = r - 2;
            ocol = w - 1;
         end else begin
            orow = r - 1;
            ocol = c - 1;
         end
         s = 0;
         if (orow != 0 && orow < h - 1 && ocol != 0 && ocol < w - 1) begin
            s = 5 * window_px[3] - window_px[0] - window_px[2] - window_px[4] - window_px[5];
            if (s < 0) s = 0;
            if (s > 255) s = 255;
         end
         exp_px.value      = s[PIX_W-1:0];
         exp_px.out_row    = orow[HEIGHT_W-1:0];
         exp_px.out_col    = ocol[ADDR_W-1:0];
         exp_px.frame_last = 1'b0;
         expected_pixels.push_back(exp_px);
         emitted = 1'b1;
      end
      window_px[5] = int'(item.pixel);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) begin
            r = 0;
            pending_border = w + 1;
            frames_done++;
         end
      end
      in_row = r;
      in_col = c;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected beat, actual %p", $realtime, rsp_payload);
            mismatches++;
         end else begin
            front_pixel = expected_pixels.pop_front();
            if (rsp_payload.value !== front_pixel.value) begin
               $display("%0t: value expected %0d actual %0d", $realtime,
                        front_pixel.value, rsp_payload.value);
               mismatches++;
            end
            if (rsp_payload.out_row !== front_pixel.out_row) begin
               $display("%0t: out_row expected %0d actual %0d", $realtime,
                        front_pixel.out_row, rsp_payload.out_row);
               mismatches++;
            end
            if (rsp_payload.out_col !== front_pixel.out_col) begin
               $display("%0t: out_col expected %0d actual %0d", $realtime,
                        front_pixel.out_col, rsp_payload.out_col);
               mismatches++;
            end
            if (rsp_payload.frame_last !== front_pixel.frame_last) begin
               $display("%0t: frame_last expected %0b actual %0b", $realtime,
                        front_pixel.frame_last, rsp_payload.frame_last);
               mismatches++;
            end
            results_checked++;
         end
      end
   end

   // receiver stall pattern, plus long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_beat(input req_type item);
      bit emitted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sharpen_predict(item, emitted);
      beats_sent++;
      if (item.kind == KIND_PIXEL || emitted) counted_items++;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pixel);
      req_type item;
      item.kind  = KIND_PIXEL;
      item.pixel = pixel;
      send_beat(item);
   endtask

   task automatic send_flush();
      req_type item;
      item.kind  = KIND_FLUSH;
      item.pixel = PIX_W'($urandom);
      send_beat(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_index, input int value);
      logic [31:0] data;
      data = $urandom;
      if (reg_index == CSR_FRAME_WIDTH) data[WIDTH_W-1:0] = value[WIDTH_W-1:0];
      else data[HEIGHT_W-1:0] = value[HEIGHT_W-1:0];
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_index == CSR_FRAME_WIDTH) width_reg = data[WIDTH_W-1:0];
      else height_reg = data[HEIGHT_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame_size(input int w, input int h);
      wait_idle();
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, h);
   endtask

   // smallest frame, both saturation limits, flush with nothing pending
   task automatic test_directed_corners();
      int bright_center [9] = '{0, 0, 0, 0, 255, 0, 0, 0, 0};
      int dark_center [9]   = '{255, 255, 255, 255, 0, 255, 255, 255, 255};
      set_frame_size(0, 0);
      foreach (bright_center[i]) send_pixel(PIX_W'(bright_center[i]));
      repeat (5) send_flush();
      foreach (dark_center[i]) send_pixel(PIX_W'(dark_center[i]));
      repeat (4) send_flush();
   endtask

   // width above the line length clamps, with a long receiver hold-off to back up the input
   task automatic test_full_width_frame();
      set_frame_size(3, 3);
      hold_request = 300;
      repeat (9) send_pixel(PIX_W'($urandom));
      wait_idle();
      write_register(CSR_FRAME_WIDTH, 2047);
      repeat (6) send_flush();
      wait_idle();
      write_register(CSR_FRAME_WIDTH, 3);
   endtask

   task automatic test_random_frames();
      int start_count, w, h, weff, heff, flushes;
      start_count = counted_items;
      while (counted_items - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0: w = $urandom_range(0, 2);
               1: w = $urandom_range(13, 40);
               default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            set_frame_size(w, h);
         end
         weff = (width_reg < 3) ? 3 : int'(width_reg);
         heff = (height_reg < 3) ? 3 : int'(height_reg);
         repeat (weff * heff) begin
            if ($urandom_range(0, 19) == 0) send_flush();
            send_pixel(PIX_W'($urandom));
         end
         case ($urandom_range(0, 19))
            0, 1, 2:    flushes = 0;
            3, 4, 5, 6: flushes = $urandom_range(1, weff);
            7, 8:       flushes = weff + 1 + $urandom_range(1, 3);
            default:    flushes = weff + 1;
         endcase
         repeat (flushes) send_flush();
      end
   endtask

   // size changes in the middle of a frame, including wrap on shrink
   task automatic test_resize_midframe();
      set_frame_size(12, 65535);
      repeat (30) send_pixel(PIX_W'($urandom));
      wait_idle();
      write_register(CSR_FRAME_WIDTH, 3);
      repeat (7) send_pixel(PIX_W'($urandom));
      wait_idle();
      write_register(CSR_FRAME_WIDTH, 12);
      repeat (15) send_pixel(PIX_W'($urandom));
      wait_idle();
      write_register(CSR_FRAME_HEIGHT, 3);
      repeat (36) send_pixel(PIX_W'($urandom));
      repeat (13) send_flush();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_full_width_frame();
      test_random_frames();
      test_resize_midframe();
      wait_idle();
      $display("Sent %0d beats over %0d complete frames (widths 3..40, clamped width, resizes)",
               beats_sent, frames_done);
      $display("Compared %0d output pixels, %0d field mismatches", results_checked, mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding", expected_pixels.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/lsh_pkg.sv
src/lsh_ctrl.sv
src/lsh_window.sv
src/lsh_out_fifo.sv
src/laplacian_sharpen_3x3.sv
src/lsh_checker.sv
dv/laplacian_sharpen_3x3_test.sv
